// File: rtl/core/sbf_pkg.sv
// Shared types and constants of the sentence boundary finder.
// Used by sentence_boundary_finder_unit and sbf_checker; depends on nothing.
package sbf_pkg;

	localparam int MAX_TEXT_LEN = 65536;
	localparam int OFS_W        = 16;
	localparam logic [OFS_W-1:0] POS_MAX = OFS_W'(MAX_TEXT_LEN - 1);

	// Sentence must span more than this many bytes before a period can end it
	localparam logic [OFS_W-1:0] MIN_DOT_SPAN = OFS_W'(3);

	localparam logic [7:0] CH_QUESTION = 8'h3F;
	localparam logic [7:0] CH_BANG     = 8'h21;
	localparam logic [7:0] CH_PERIOD   = 8'h2E;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_CAP_A    = 8'h41;
	localparam logic [7:0] CH_CAP_Z    = 8'h5A;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		PEND_NONE = 2'd0,
		PEND_QE   = 2'd1,
		PEND_DOT  = 2'd2
	} pend_t;

	typedef struct packed {
		logic [OFS_W-1:0] start_ofs;
		logic [OFS_W-1:0] end_ofs;
		logic             fin;
		logic             run_last;
	} res_t;

	function automatic logic is_capital(input logic [7:0] b);
		is_capital = (b >= CH_CAP_A) && (b <= CH_CAP_Z);
	endfunction

endpackage

// File: rtl/core/sentence_boundary_finder_unit.sv
// Sentence boundary finder top level: per-byte decision logic and result queue.
// Depends on sbf_pkg.
//
// Text enters one byte per cycle; each accepted byte is judged in the cycle it
// arrives, from a few state registers (position, open sentence start, the three
// bytes before, pending end), and its zero, one or two results go straight into
// a four-entry result queue that drives the output. A byte can be accepted in
// every cycle while the queue has room for two results; the queue drains one
// result per cycle while out_stall is low; the two results a last byte often
// yields leave in turn. in_stall rises when three or more results are queued.
// Offsets saturate at MAX_TEXT_LEN-1, and all decision state returns to reset
// after the byte flagged text_last; the result queue keeps its contents.
module sentence_boundary_finder_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [7:0]               text_byte,
	input  logic                     text_last,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [sbf_pkg::OFS_W-1:0] sentence_start,
	output logic [sbf_pkg::OFS_W-1:0] sentence_end,
	output logic                     text_final,
	output logic                     run_last
);

	logic [sbf_pkg::OFS_W-1:0] pos_q;
	logic [sbf_pkg::OFS_W-1:0] start_q;
	logic [7:0]                back1_q;
	logic [7:0]                back2_q;
	logic [7:0]                back3_q;
	sbf_pkg::pend_t            pend_q;

	sbf_pkg::res_t             fifo_q [sbf_pkg::FIFO_DEPTH];
	logic [sbf_pkg::PTR_W-1:0] wr_ptr_q;
	logic [sbf_pkg::PTR_W-1:0] rd_ptr_q;
	logic [sbf_pkg::CNT_W-1:0] cnt_q;

	logic                      in_acc;
	logic                      out_acc;
	logic                      resolve;
	logic                      end_pend;
	logic [sbf_pkg::OFS_W-1:0] pend_end;
	logic [sbf_pkg::OFS_W-1:0] start_mid;
	sbf_pkg::pend_t            pend_mid;
	sbf_pkg::pend_t            pend_nxt;
	logic                      dot_ok;
	sbf_pkg::res_t             res_a;
	sbf_pkg::res_t             res_b;
	logic                      push_a;
	logic                      push_b;
	logic [sbf_pkg::CNT_W-1:0] push_n;
	sbf_pkg::res_t             head;

	assign in_stall = cnt_q >= sbf_pkg::CNT_W'(sbf_pkg::FIFO_DEPTH - 1);
	assign in_acc   = in_valid && !in_stall;
	assign out_valid = cnt_q != '0;
	assign out_acc  = out_valid && !out_stall;

	// Resolve a pending end on the first non-space byte
	always_comb begin
		resolve   = (pend_q != sbf_pkg::PEND_NONE) && (text_byte != sbf_pkg::CH_SPACE);
		end_pend  = resolve &&
			((pend_q == sbf_pkg::PEND_QE) || sbf_pkg::is_capital(text_byte));
		pend_end  = (pos_q == '0) ? '0 : pos_q - sbf_pkg::OFS_W'(1);
		start_mid = end_pend ? pos_q : start_q;
		pend_mid  = resolve ? sbf_pkg::PEND_NONE : pend_q;
		dot_ok    = (text_byte == sbf_pkg::CH_PERIOD) && (pos_q >= start_mid) &&
			((pos_q - start_mid) > sbf_pkg::MIN_DOT_SPAN) &&
			(back3_q != sbf_pkg::CH_SPACE) && (back2_q != sbf_pkg::CH_PERIOD);
		pend_nxt  = pend_mid;
		if (pend_mid == sbf_pkg::PEND_NONE) begin
			if ((text_byte == sbf_pkg::CH_QUESTION) || (text_byte == sbf_pkg::CH_BANG)) begin
				pend_nxt = sbf_pkg::PEND_QE;
			end else if (dot_ok) begin
				pend_nxt = sbf_pkg::PEND_DOT;
			end
		end
	end

	// Pack results: res_a goes first, res_b only when both exist
	always_comb begin
		res_a.start_ofs = start_q;
		res_a.end_ofs   = pend_end;
		res_a.fin       = 1'b0;
		res_a.run_last  = !text_last;
		res_b.start_ofs = start_mid;
		res_b.end_ofs   = pos_q;
		res_b.fin       = 1'b1;
		res_b.run_last  = 1'b1;
		push_a = 1'b0;
		push_b = 1'b0;
		if (in_acc) begin
			if (end_pend) begin
				push_a = 1'b1;
				push_b = text_last;
			end else if (text_last) begin
				res_a  = res_b;
				push_a = 1'b1;
			end
		end
		push_n = sbf_pkg::CNT_W'(push_a) + sbf_pkg::CNT_W'(push_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			start_q <= '0;
			back1_q <= '0;
			back2_q <= '0;
			back3_q <= '0;
			pend_q  <= sbf_pkg::PEND_NONE;
		end else if (in_acc) begin
			if (text_last) begin
				pos_q   <= '0;
				start_q <= '0;
				back1_q <= '0;
				back2_q <= '0;
				back3_q <= '0;
				pend_q  <= sbf_pkg::PEND_NONE;
			end else begin
				if (pos_q != sbf_pkg::POS_MAX) begin
					pos_q <= pos_q + sbf_pkg::OFS_W'(1);
				end
				start_q <= start_mid;
				back1_q <= text_byte;
				back2_q <= back1_q;
				back3_q <= back2_q;
				pend_q  <= pend_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + sbf_pkg::PTR_W'(push_n);
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + sbf_pkg::PTR_W'(1);
			end
			cnt_q <= cnt_q + push_n - sbf_pkg::CNT_W'(out_acc);
		end
	end

	always_ff @(posedge clk) begin
		if (push_a) begin
			fifo_q[wr_ptr_q] <= res_a;
		end
		if (push_b) begin
			fifo_q[wr_ptr_q + sbf_pkg::PTR_W'(1)] <= res_b;
		end
	end

	assign head           = fifo_q[rd_ptr_q];
	assign sentence_start = head.start_ofs;
	assign sentence_end   = head.end_ofs;
	assign text_final     = head.fin;
	assign run_last       = head.run_last;

endmodule

// File: rtl/core/sbf_checker.sv
// Port-level checks for sentence_boundary_finder_unit, bound to the top level.
// Depends on sbf_pkg.
module sbf_port_props (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      text_last,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [sbf_pkg::OFS_W-1:0] sentence_start,
	input logic [sbf_pkg::OFS_W-1:0] sentence_end,
	input logic                      text_final,
	input logic                      run_last
);

	// Hold a stalled item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(sentence_start) && $stable(sentence_end) &&
			$stable(text_final) && $stable(run_last))
		else $error("stalled result changed");

	// The final sentence is always the last result of its byte
	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && text_final |-> run_last)
		else $error("final sentence without run_last");

	// A last byte always yields a queued result on the next cycle
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && text_last |=> out_valid)
		else $error("no result after last byte");

endmodule

bind sentence_boundary_finder_unit sbf_port_props u_sbf_port_props (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.text_last      (text_last),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.sentence_start (sentence_start),
	.sentence_end   (sentence_end),
	.text_final     (text_final),
	.run_last       (run_last)
);
